/* hdl/sas_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite animation sequencer package
// Shared types, request codes and register indexes for the sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int FrameBits = 8;
	localparam int DeltaBits = 16;
	localparam int CellBits  = 11;
	localparam int RectBits  = 18;
	localparam int ActBits   = 9;

	typedef logic [FrameBits-1:0] frame_t;
	typedef logic [DeltaBits-1:0] ticks_t;
	typedef logic [CellBits-1:0]  cell_t;
	typedef logic [RectBits-1:0]  rect_t;
	typedef logic signed [ActBits-1:0] act_t;

	// An action bound holding this value turns the action window off.
	localparam act_t ActionOff = '1;

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_PLAY  = 3'd1,
		REQ_PAUSE = 3'd2,
		REQ_STOP  = 3'd3,
		REQ_SET   = 3'd4
	} req_e;

	typedef enum logic [2:0] {
		CFG_START_FRAME = 3'd0,
		CFG_END_FRAME   = 3'd1,
		CFG_SHEET_ROW   = 3'd2,
		CFG_TICKS       = 3'd3,
		CFG_ACT_FIRST   = 3'd4,
		CFG_ACT_LAST    = 3'd5,
		CFG_CELL_W      = 3'd6,
		CFG_CELL_H      = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		frame_t start_frame;
		frame_t end_frame;
		frame_t sheet_row;
		ticks_t ticks_per_frame;
		act_t   action_first;
		act_t   action_last;
		cell_t  cell_width;
		cell_t  cell_height;
	} cfg_t;

	typedef struct packed {
		logic [2:0] req_type;
		ticks_t     delta_ticks;
		logic       loop_flag;
		frame_t     frame_request;
	} req_t;

	typedef struct packed {
		frame_t frame_index;
		rect_t  rect_x;
		rect_t  rect_y;
		logic   is_playing;
		logic   in_action;
	} res_t;

endpackage

/* hdl/sas_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Sprite animation sequencer configuration registers
// Holds the animation span, timing, action window and cell size.
// ----------------------------------------------------------------------------
module sas_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output sas_pkg::cfg_t     cfg
);

	sas_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_frame     <= '0;
			cfg_q.end_frame       <= '0;
			cfg_q.sheet_row       <= '0;
			cfg_q.ticks_per_frame <= '0;
			cfg_q.action_first    <= sas_pkg::ActionOff;
			cfg_q.action_last     <= sas_pkg::ActionOff;
			cfg_q.cell_width      <= sas_pkg::cell_t'(1);
			cfg_q.cell_height     <= sas_pkg::cell_t'(1);
		end else if (wr_en) begin
			case (sas_pkg::cfg_idx_e'(wr_index))
				sas_pkg::CFG_START_FRAME: cfg_q.start_frame <= wr_data[sas_pkg::FrameBits-1:0];
				sas_pkg::CFG_END_FRAME:   cfg_q.end_frame   <= wr_data[sas_pkg::FrameBits-1:0];
				sas_pkg::CFG_SHEET_ROW:   cfg_q.sheet_row   <= wr_data[sas_pkg::FrameBits-1:0];
				sas_pkg::CFG_TICKS:       cfg_q.ticks_per_frame <= wr_data;
				sas_pkg::CFG_ACT_FIRST:   cfg_q.action_first <= wr_data[sas_pkg::ActBits-1:0];
				sas_pkg::CFG_ACT_LAST:    cfg_q.action_last  <= wr_data[sas_pkg::ActBits-1:0];
				sas_pkg::CFG_CELL_W:      cfg_q.cell_width  <= wr_data[sas_pkg::CellBits-1:0];
				sas_pkg::CFG_CELL_H:      cfg_q.cell_height <= wr_data[sas_pkg::CellBits-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/sas_core.sv */
// ----------------------------------------------------------------------------
// Sprite animation sequencer core
// Animation state, next-state logic for one request, and the result register.
// ----------------------------------------------------------------------------
module sas_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  sas_pkg::req_t req,
	input  sas_pkg::cfg_t cfg,
	output sas_pkg::res_t res
);

	sas_pkg::frame_t frame_q;
	sas_pkg::ticks_t elapsed_q;
	logic            playing_q;
	logic            looping_q;
	sas_pkg::res_t   res_s2;

	sas_pkg::frame_t frame_nxt;
	sas_pkg::ticks_t elapsed_nxt;
	logic            playing_nxt;
	logic            looping_nxt;

	logic [sas_pkg::DeltaBits:0] tick_sum;
	sas_pkg::ticks_t             tick_sat;
	logic                        step_due;
	logic                        span_up;
	logic                        span_flat;
	logic                        passed_end;
	sas_pkg::frame_t             step_frame;
	logic                        step_playing;
	logic                        want_in_span;
	logic [sas_pkg::RectBits:0]  prod_x;
	logic [sas_pkg::RectBits:0]  prod_y;
	logic                        window_hit;

	// Frame step toward the end frame. An ascending step from the end frame
	// or above, or a descending step from the end frame or below, passes it.
	always_comb begin
		span_flat = (cfg.start_frame == cfg.end_frame);
		span_up   = (cfg.start_frame < cfg.end_frame);
		if (span_up) begin
			passed_end = (frame_q >= cfg.end_frame);
		end else begin
			passed_end = (frame_q <= cfg.end_frame);
		end
		step_frame   = frame_q;
		step_playing = playing_q;
		if (!span_flat) begin
			if (passed_end) begin
				if (looping_q) begin
					step_frame = cfg.start_frame;
				end else begin
					step_frame   = cfg.end_frame;
					step_playing = 1'b0;
				end
			end else if (span_up) begin
				step_frame = frame_q + sas_pkg::frame_t'(1);
			end else begin
				step_frame = frame_q - sas_pkg::frame_t'(1);
			end
		end
	end

	always_comb begin
		tick_sum = {1'b0, elapsed_q} + {1'b0, req.delta_ticks};
		tick_sat = tick_sum[sas_pkg::DeltaBits] ? '1 : tick_sum[sas_pkg::DeltaBits-1:0];
		step_due = (tick_sat >= cfg.ticks_per_frame);
		want_in_span =
			((req.frame_request >= cfg.start_frame) && (req.frame_request <= cfg.end_frame)) ||
			((req.frame_request >= cfg.end_frame) && (req.frame_request <= cfg.start_frame));

		frame_nxt   = frame_q;
		elapsed_nxt = elapsed_q;
		playing_nxt = playing_q;
		looping_nxt = looping_q;
		case (sas_pkg::req_e'(req.req_type))
			sas_pkg::REQ_TICK: begin
				if (playing_q) begin
					if (step_due) begin
						frame_nxt   = step_frame;
						playing_nxt = step_playing;
						elapsed_nxt = '0;
					end else begin
						elapsed_nxt = tick_sat;
					end
				end
			end
			sas_pkg::REQ_PLAY: begin
				looping_nxt = req.loop_flag;
				playing_nxt = 1'b1;
			end
			sas_pkg::REQ_PAUSE: begin
				playing_nxt = 1'b0;
			end
			sas_pkg::REQ_STOP: begin
				playing_nxt = 1'b0;
				frame_nxt   = cfg.start_frame;
				elapsed_nxt = '0;
			end
			sas_pkg::REQ_SET: begin
				if (want_in_span) begin
					frame_nxt = req.frame_request;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		prod_x = (sas_pkg::RectBits+1)'(cfg.cell_width) * (sas_pkg::RectBits+1)'(frame_nxt);
		prod_y = (sas_pkg::RectBits+1)'(cfg.cell_height) * (sas_pkg::RectBits+1)'(cfg.sheet_row);
		window_hit = ($signed({1'b0, frame_nxt}) >= cfg.action_first) &&
			($signed({1'b0, frame_nxt}) <= cfg.action_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			elapsed_q <= '0;
			playing_q <= 1'b0;
			looping_q <= 1'b0;
		end else if (fire) begin
			frame_q   <= frame_nxt;
			elapsed_q <= elapsed_nxt;
			playing_q <= playing_nxt;
			looping_q <= looping_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.frame_index <= frame_nxt;
			res_s2.rect_x      <= prod_x[sas_pkg::RectBits-1:0];
			res_s2.rect_y      <= prod_y[sas_pkg::RectBits-1:0];
			res_s2.is_playing  <= playing_nxt;
			res_s2.in_action   <= (cfg.action_first == sas_pkg::ActionOff) ||
				(cfg.action_last == sas_pkg::ActionOff) || window_hit;
		end
	end

	assign res = res_s2;

	// Playing only starts on a play request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(playing_q) |-> $past(fire && (req.req_type == sas_pkg::REQ_PLAY)))
		else $error("playing started without a play request");

	// A stop request rewinds to the start frame and clears elapsed time.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.req_type == sas_pkg::REQ_STOP) |=>
			(frame_q == $past(cfg.start_frame)) && !playing_q && (elapsed_q == '0))
		else $error("stop did not rewind the animation");

	// State only moves when a request is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(frame_q) && $stable(elapsed_q) && $stable(playing_q) &&
			$stable(looping_q))
		else $error("animation state changed without a request");

	// The result register reports the state left by its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (res_s2.frame_index == frame_q) && (res_s2.is_playing == playing_q))
		else $error("result does not match animation state");

endmodule

/* hdl/sprite_animation_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Sprite animation sequencer unit
// Steps a sprite frame on tick, play, pause, stop and set-frame requests.
// ----------------------------------------------------------------------------
// Each accepted request produces exactly one result, in order. The unit
// accepts one request per clock cycle while the result side is not stalled;
// each request waits in the input register, then makes a single pass through
// the state update and the frame-to-pixel multiply into the result register.
// The state update is what sets the rate, since every request reads the
// frame, elapsed time and play flags left by the one before it. The input and
// output registers form a two-stage pipeline, so a waiting result does not
// stop the next request from being taken as long as one stage is free. The
// configuration port is always ready. Registers are to be written only while
// no request is in flight; cell widths and heights are taken as written, and
// an action bound of all ones turns the action window off.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] delta_ticks, [16] loop_flag, [24:17] frame_request, [31:25] zero
	input  logic [31:0] s_tdata,
	// [2:0] req_type
	input  logic [2:0]  s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] frame_index, [25:8] rect_x, [43:26] rect_y, [44] is_playing,
	// [45] in_action, [47:46] zero
	output logic [47:0] m_tdata,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sas_pkg::cfg_t cfg;
	sas_pkg::req_t req_s1;
	sas_pkg::res_t res;
	logic          valid_s1;
	logic          valid_s2;
	logic          advance;
	logic          core_fire;

	assign cfg_ready = 1'b1;

	sas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result stage moves whenever it is empty or being drained, and the
	// input stage refills in the same cycle it hands its request on.
	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign core_fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.req_type      <= s_tuser;
			req_s1.delta_ticks   <= s_tdata[15:0];
			req_s1.loop_flag     <= s_tdata[16];
			req_s1.frame_request <= s_tdata[24:17];
		end
	end

	sas_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (core_fire),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res.in_action, res.is_playing, res.rect_y, res.rect_x,
		res.frame_index};

endmodule

/* verif/sprite_animation_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// Sprite animation sequencer unit testbench
// Drives play, pause, stop, tick and set-frame requests into the sequencer
// with random gaps and back-pressure, tracks the animation state in a
// scoreboard and checks every returned frame, rectangle origin and flag.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// The request code field is three bits wide, so codes above the last
	// defined request are legal on the wire and must leave the state alone.
	localparam logic [2:0] ReqCodeTop = '1;

	// Receiver hold-off used once to fill both pipeline stages.
	localparam int LongHoldCycles = 64;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the registers and the animation state,
	// works out the result of every accepted request and compares results.
	// ------------------------------------------------------------------------
	class anim_frame_tracker;
		sas_pkg::cfg_t   regs;
		sas_pkg::frame_t frame;
		sas_pkg::ticks_t elapsed;
		bit              playing;
		bit              looping;
		sas_pkg::res_t   expected_q[$];
		int              mismatches;

		function new();
			regs              = '0;
			regs.action_first = sas_pkg::ActionOff;
			regs.action_last  = sas_pkg::ActionOff;
			regs.cell_width   = sas_pkg::cell_t'(1);
			regs.cell_height  = sas_pkg::cell_t'(1);
			frame             = '0;
			elapsed           = '0;
			playing           = 1'b0;
			looping           = 1'b0;
			mismatches        = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(sas_pkg::cfg_idx_e idx, logic [15:0] data);
			case (idx)
				sas_pkg::CFG_START_FRAME: regs.start_frame     = data[7:0];
				sas_pkg::CFG_END_FRAME:   regs.end_frame       = data[7:0];
				sas_pkg::CFG_SHEET_ROW:   regs.sheet_row       = data[7:0];
				sas_pkg::CFG_TICKS:       regs.ticks_per_frame = data;
				sas_pkg::CFG_ACT_FIRST:   regs.action_first    = data[8:0];
				sas_pkg::CFG_ACT_LAST:    regs.action_last     = data[8:0];
				sas_pkg::CFG_CELL_W:      regs.cell_width      = data[10:0];
				sas_pkg::CFG_CELL_H:      regs.cell_height     = data[10:0];
				default: ;
			endcase
		endfunction

		// One frame step toward the end frame. Running off the end, including
		// an 8-bit wrap in either direction, either loops or parks on the end.
		function void step_frame();
			int nxt;
			bit passed;
			if (regs.start_frame == regs.end_frame)
				return;
			if (regs.start_frame < regs.end_frame) begin
				nxt    = int'(frame) + 1;
				passed = nxt > int'(regs.end_frame);
			end else begin
				nxt    = int'(frame) - 1;
				passed = nxt < int'(regs.end_frame);
			end
			if (!passed) begin
				frame = sas_pkg::frame_t'(nxt);
			end else if (looping) begin
				frame = regs.start_frame;
			end else begin
				frame   = regs.end_frame;
				playing = 1'b0;
			end
		endfunction

		function void note_request(logic [2:0] code, sas_pkg::ticks_t delta, bit loop_in,
		                           sas_pkg::frame_t want);
			logic [16:0]   sum;
			int unsigned   prod_x;
			int unsigned   prod_y;
			int            f;
			sas_pkg::res_t r;
			case (code)
				sas_pkg::REQ_TICK: begin
					if (playing) begin
						sum     = {1'b0, elapsed} + {1'b0, delta};
						elapsed = sum[16] ? '1 : sum[15:0];
						if (elapsed >= regs.ticks_per_frame) begin
							step_frame();
							elapsed = '0;
						end
					end
				end
				sas_pkg::REQ_PLAY: begin
					looping = loop_in;
					playing = 1'b1;
				end
				sas_pkg::REQ_PAUSE: playing = 1'b0;
				sas_pkg::REQ_STOP: begin
					playing = 1'b0;
					frame   = regs.start_frame;
					elapsed = '0;
				end
				sas_pkg::REQ_SET: begin
					if ((want >= regs.start_frame && want <= regs.end_frame) ||
					    (want >= regs.end_frame && want <= regs.start_frame))
						frame = want;
				end
				default: ;
			endcase
			prod_x        = regs.cell_width * frame;
			prod_y        = regs.cell_height * regs.sheet_row;
			f             = int'(frame);
			r.frame_index = frame;
			r.rect_x      = prod_x[sas_pkg::RectBits-1:0];
			r.rect_y      = prod_y[sas_pkg::RectBits-1:0];
			r.is_playing  = playing;
			r.in_action   = (regs.action_first == sas_pkg::ActionOff) ||
			                (regs.action_last == sas_pkg::ActionOff) ||
			                (f >= $signed(regs.action_first) && f <= $signed(regs.action_last));
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want_v, int unsigned got_v);
			if (want_v != got_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_result(logic [47:0] word);
			sas_pkg::res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request pending, expected none, actual %h",
				         $time, word);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("frame_index", want.frame_index, word[7:0]);
			compare_field("rect_x", want.rect_x, word[25:8]);
			compare_field("rect_y", want.rect_y, word[43:26]);
			compare_field("is_playing", want.is_playing, word[44]);
			compare_field("in_action", want.in_action, word[45]);
			compare_field("padding", 0, word[47:46]);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the unit under test.
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// Shared between the two sides: no idle cycles at all while steady is set,
	// and a single long receiver hold-off when hold_off_req is raised.
	bit steady       = 1'b0;
	bit hold_off_req = 1'b0;

	anim_frame_tracker tracker = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sprite_animation_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Drivers. Inputs change on the falling edge; handshakes are judged on the
	// rising edge, where the values seen are the ones from before the edge.
	// ------------------------------------------------------------------------

	// Register write; the predictor takes the value at the same edge as the
	// unit does. The valid is dropped on the following falling edge.
	task automatic write_reg(input sas_pkg::cfg_idx_e idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering requests and waits for every outstanding result. Every
	// request returns a result, so the extra wait after the last one is ample margin.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input sas_pkg::frame_t first_col,
	                            input sas_pkg::frame_t last_col,
	                            input sas_pkg::frame_t row, input sas_pkg::ticks_t tpf,
	                            input sas_pkg::act_t act_lo, input sas_pkg::act_t act_hi,
	                            input sas_pkg::cell_t cw, input sas_pkg::cell_t ch);
		drain();
		write_reg(sas_pkg::CFG_START_FRAME, {8'b0, first_col});
		write_reg(sas_pkg::CFG_END_FRAME, {8'b0, last_col});
		write_reg(sas_pkg::CFG_SHEET_ROW, {8'b0, row});
		write_reg(sas_pkg::CFG_TICKS, tpf);
		write_reg(sas_pkg::CFG_ACT_FIRST, {7'b0, act_lo});
		write_reg(sas_pkg::CFG_ACT_LAST, {7'b0, act_hi});
		write_reg(sas_pkg::CFG_CELL_W, {5'b0, cw});
		write_reg(sas_pkg::CFG_CELL_H, {5'b0, ch});
	endtask

	// Offers one request after a random gap. The valid stays high when the
	// next request follows straight on, so it is never lowered and raised in
	// the same step.
	task automatic send_request(input logic [2:0] code, input sas_pkg::ticks_t delta,
	                            input bit loop_in, input sas_pkg::frame_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {7'b0, want, loop_in, delta};
		do @(posedge clk); while (!s_tready);
		tracker.note_request(code, delta, loop_in, want);
	endtask

	function automatic sas_pkg::cell_t pick_cell();
		case ($urandom_range(0, 3))
			0:       return sas_pkg::cell_t'(1);
			1:       return sas_pkg::cell_t'(1024);
			default: return sas_pkg::cell_t'($urandom_range(1, 1024));
		endcase
	endfunction

	// Random animation setup. The first phases pin the extremes: a full
	// ascending sweep over all 256 columns with the largest cells, a full
	// descending sweep, and a span whose start equals its end.
	task automatic random_setup(input int phase);
		sas_pkg::frame_t a;
		sas_pkg::frame_t b;
		sas_pkg::frame_t row;
		sas_pkg::ticks_t tpf;
		sas_pkg::act_t   act_lo;
		sas_pkg::act_t   act_hi;
		sas_pkg::cell_t  cw;
		sas_pkg::cell_t  ch;
		a = sas_pkg::frame_t'($urandom);
		if ($urandom_range(0, 3) == 0)
			b = sas_pkg::frame_t'($urandom);
		else
			b = sas_pkg::frame_t'(a + sas_pkg::frame_t'($urandom_range(0, 12)) - 6);
		row = sas_pkg::frame_t'($urandom);
		case ($urandom_range(0, 9))
			0:       tpf = '0;
			1:       tpf = sas_pkg::ticks_t'($urandom);
			default: tpf = sas_pkg::ticks_t'($urandom_range(1, 6));
		endcase
		act_lo = ($urandom_range(0, 3) == 0) ? sas_pkg::ActionOff :
		         sas_pkg::act_t'($urandom_range(0, 255));
		act_hi = ($urandom_range(0, 3) == 0) ? sas_pkg::ActionOff :
		         sas_pkg::act_t'($urandom_range(0, 255));
		cw = pick_cell();
		ch = pick_cell();
		case (phase)
			0: begin
				a   = '0;
				b   = '1;
				tpf = '0;
				row = '1;
				cw  = sas_pkg::cell_t'(1024);
				ch  = sas_pkg::cell_t'(1024);
			end
			1: begin
				a   = '1;
				b   = '0;
				tpf = sas_pkg::ticks_t'(1);
				row = '0;
			end
			2: b = a;
			default: ;
		endcase
		program_regs(a, b, row, tpf, act_lo, act_hi, cw, ch);
	endtask

	// Mostly ticks while playing, so the frame keeps moving through the span
	// and past its end; the rest are play, pause, stop, set-frame and codes
	// the unit must ignore. Fields a request does not use still carry noise.
	task automatic random_request();
		logic [2:0]      code;
		sas_pkg::ticks_t delta;
		sas_pkg::frame_t want;
		sas_pkg::frame_t lo;
		sas_pkg::frame_t hi;
		int              pick;
		pick = $urandom_range(0, 99);
		if (pick < 52)
			code = sas_pkg::REQ_TICK;
		else if (pick < 62)
			code = sas_pkg::REQ_PLAY;
		else if (pick < 68)
			code = sas_pkg::REQ_PAUSE;
		else if (pick < 73)
			code = sas_pkg::REQ_STOP;
		else if (pick < 93)
			code = sas_pkg::REQ_SET;
		else
			code = 3'($urandom_range(int'(sas_pkg::REQ_SET) + 1, int'(ReqCodeTop)));
		if (!tracker.playing && code == sas_pkg::REQ_TICK && $urandom_range(0, 1) == 1)
			code = sas_pkg::REQ_PLAY;
		case ($urandom_range(0, 5))
			0:       delta = '1;
			1:       delta = sas_pkg::ticks_t'($urandom);
			default: delta = sas_pkg::ticks_t'($urandom_range(0,
			                 int'(tracker.regs.ticks_per_frame) + 1));
		endcase
		lo = (tracker.regs.start_frame < tracker.regs.end_frame) ?
		     tracker.regs.start_frame : tracker.regs.end_frame;
		hi = (tracker.regs.start_frame < tracker.regs.end_frame) ?
		     tracker.regs.end_frame : tracker.regs.start_frame;
		if ($urandom_range(0, 9) < 7)
			want = sas_pkg::frame_t'($urandom_range(int'(lo), int'(hi)));
		else
			want = sas_pkg::frame_t'($urandom);
		send_request(code, delta, 1'($urandom), want);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stalls before each result, a long hold-off on
	// request, and a check of every result taken.
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (LongHoldCycles) @(negedge clk);
			end
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.check_result(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = sas_pkg::REQ_TICK;
		cfg_valid = 1'b0;
		cfg_index = sas_pkg::CFG_START_FRAME;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Short ascending span with a narrow action window. A tick while
		// paused does nothing, a set-frame outside the span is dropped,
		// looping play wraps to the start, and one-shot play parks on the
		// end frame and stops playing.
		program_regs(8'd2, 8'd5, 8'd3, 16'd2, sas_pkg::act_t'(3), sas_pkg::act_t'(4),
		             sas_pkg::cell_t'(16), sas_pkg::cell_t'(1024));
		send_request(sas_pkg::REQ_TICK, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_SET, '0, 1'b0, 8'd4);
		send_request(sas_pkg::REQ_SET, '0, 1'b0, 8'd9);
		send_request(sas_pkg::REQ_PLAY, '0, 1'b1, '0);
		send_request(sas_pkg::REQ_TICK, 16'd1, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, 16'd1, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, 16'd2, 1'b0, '0);
		send_request(sas_pkg::REQ_PAUSE, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, '1, 1'b0, '0);
		send_request(sas_pkg::REQ_PLAY, '0, 1'b0, '0);
		repeat (4) send_request(sas_pkg::REQ_TICK, '1, 1'b0, '0);
		send_request(sas_pkg::REQ_STOP, '0, 1'b0, '0);
		send_request(ReqCodeTop, '1, 1'b1, '1);

		// Full descending span, a step on every tick. Stepping below
		// column zero counts as passing the end: one-shot play parks on the
		// end, looping play goes back to the top column.
		program_regs('1, '0, '1, '0, sas_pkg::ActionOff, sas_pkg::act_t'(200),
		             sas_pkg::cell_t'(1024), sas_pkg::cell_t'(1));
		send_request(sas_pkg::REQ_PLAY, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_SET, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_PLAY, '0, 1'b1, '0);
		send_request(sas_pkg::REQ_TICK, '0, 1'b0, '0);

		// Full ascending span with the slowest frame time: two large ticks
		// saturate the elapsed count, and stepping past the top column
		// wraps to the start.
		program_regs('0, '1, '0, '1, sas_pkg::act_t'(0), sas_pkg::act_t'(255),
		             sas_pkg::cell_t'(1), sas_pkg::cell_t'(1024));
		send_request(sas_pkg::REQ_PLAY, '0, 1'b1, '0);
		send_request(sas_pkg::REQ_SET, '0, 1'b0, '1);
		send_request(sas_pkg::REQ_TICK, 16'd40000, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, 16'd40000, 1'b0, '0);

		// Start equals end: a step leaves the frame and the play flag alone.
		program_regs(8'd7, 8'd7, 8'd1, '0, sas_pkg::ActionOff, sas_pkg::ActionOff,
		             sas_pkg::cell_t'(3), sas_pkg::cell_t'(5));
		send_request(sas_pkg::REQ_PLAY, '0, 1'b0, '0);
		send_request(sas_pkg::REQ_TICK, 16'd9, 1'b0, '0);

		// Random phases. Every third phase runs with no idle cycles on either
		// side. In one phase the receiver holds off long enough for the unit
		// to stall its input, and in another the sender stops halfway and
		// waits for every result before going on.
		for (int phase = 0; phase < 12; phase++) begin
			random_setup(phase);
			steady = (phase % 3 == 2);
			if (phase == 4)
				hold_off_req = 1'b1;
			for (int n = 0; n < 42; n++) begin
				random_request();
				if (phase == 7 && n == 20)
					drain();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: the whole run needs well under a tenth of this.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
